### hw/rtl/pftb_pkg.sv
// Shared types, constants and glyph table for the page framebuffer text blitter.
package pftb_pkg;

    localparam int STORE_DEPTH = 1024;
    localparam int STORE_AW    = 10;
    localparam int CHAR_PITCH  = 6;
    localparam int GLYPH_COLS  = 5;
    localparam int GLYPH_ROWS  = 7;
    localparam logic [7:0] CODE_FIRST  = 8'd32;
    localparam logic [7:0] CODE_LAST   = 8'd127;
    localparam logic [7:0] CODE_SUBST  = 8'h3F;

    typedef enum logic [1:0] {
        REQ_PIXEL = 2'd0,
        REQ_TEXT  = 2'd1,
        REQ_READ  = 2'd2,
        REQ_CLEAR = 2'd3
    } req_kind_t;

    typedef enum logic [1:0] {
        ALIGN_LEFT   = 2'd0,
        ALIGN_CENTER = 2'd1,
        ALIGN_RIGHT  = 2'd2
    } align_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_ERROR   = 2'd1,
        STAT_CLIPPED = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CLEAR,
        ST_TCOL,
        ST_RD,
        ST_WR,
        ST_RDATA,
        ST_DONE
    } state_t;

    // Glyph columns packed first column in the top byte.
    function automatic logic [39:0] glyph_bits(input logic [6:0] gi);
        logic [39:0] g;
        case (gi)
            7'd0:  g = 40'h00_00_00_00_00;
            7'd1:  g = 40'h00_00_5F_00_00;
            7'd2:  g = 40'h00_07_00_07_00;
            7'd3:  g = 40'h14_7F_14_7F_14;
            7'd4:  g = 40'h24_2A_7F_2A_12;
            7'd5:  g = 40'h23_13_08_64_62;
            7'd6:  g = 40'h36_49_55_22_50;
            7'd7:  g = 40'h00_05_03_00_00;
            7'd8:  g = 40'h00_1C_22_41_00;
            7'd9:  g = 40'h00_41_22_1C_00;
            7'd10: g = 40'h14_08_3E_08_14;
            7'd11: g = 40'h08_08_3E_08_08;
            7'd12: g = 40'h00_50_30_00_00;
            7'd13: g = 40'h08_08_08_08_08;
            7'd14: g = 40'h00_60_60_00_00;
            7'd15: g = 40'h20_10_08_04_02;
            7'd16: g = 40'h3E_51_49_45_3E;
            7'd17: g = 40'h00_42_7F_40_00;
            7'd18: g = 40'h42_61_51_49_46;
            7'd19: g = 40'h21_41_45_4B_31;
            7'd20: g = 40'h18_14_12_7F_10;
            7'd21: g = 40'h27_45_45_45_39;
            7'd22: g = 40'h3C_4A_49_49_30;
            7'd23: g = 40'h01_71_09_05_03;
            7'd24: g = 40'h36_49_49_49_36;
            7'd25: g = 40'h06_49_49_29_1E;
            7'd26: g = 40'h00_36_36_00_00;
            7'd27: g = 40'h00_56_36_00_00;
            7'd28: g = 40'h08_14_22_41_00;
            7'd29: g = 40'h14_14_14_14_14;
            7'd30: g = 40'h00_41_22_14_08;
            7'd31: g = 40'h02_01_51_09_06;
            7'd32: g = 40'h32_49_79_41_3E;
            7'd33: g = 40'h7E_11_11_11_7E;
            7'd34: g = 40'h7F_49_49_49_36;
            7'd35: g = 40'h3E_41_41_41_22;
            7'd36: g = 40'h7F_41_41_22_1C;
            7'd37: g = 40'h7F_49_49_49_41;
            7'd38: g = 40'h7F_09_09_09_01;
            7'd39: g = 40'h3E_41_49_49_7A;
            7'd40: g = 40'h7F_08_08_08_7F;
            7'd41: g = 40'h00_41_7F_41_00;
            7'd42: g = 40'h20_40_41_3F_01;
            7'd43: g = 40'h7F_08_14_22_41;
            7'd44: g = 40'h7F_40_40_40_40;
            7'd45: g = 40'h7F_02_0C_02_7F;
            7'd46: g = 40'h7F_04_08_10_7F;
            7'd47: g = 40'h3E_41_41_41_3E;
            7'd48: g = 40'h7F_09_09_09_06;
            7'd49: g = 40'h3E_41_51_21_5E;
            7'd50: g = 40'h7F_09_19_29_46;
            7'd51: g = 40'h46_49_49_49_31;
            7'd52: g = 40'h01_01_7F_01_01;
            7'd53: g = 40'h3F_40_40_40_3F;
            7'd54: g = 40'h1F_20_40_20_1F;
            7'd55: g = 40'h3F_40_38_40_3F;
            7'd56: g = 40'h63_14_08_14_63;
            7'd57: g = 40'h07_08_70_08_07;
            7'd58: g = 40'h61_51_49_45_43;
            7'd59: g = 40'h00_7F_41_41_00;
            7'd60: g = 40'h02_04_08_10_20;
            7'd61: g = 40'h00_41_41_7F_00;
            7'd62: g = 40'h04_02_01_02_04;
            7'd63: g = 40'h40_40_40_40_40;
            7'd64: g = 40'h00_01_02_04_00;
            7'd65: g = 40'h20_54_54_54_78;
            7'd66: g = 40'h7F_48_44_44_38;
            7'd67: g = 40'h38_44_44_44_20;
            7'd68: g = 40'h38_44_44_48_7F;
            7'd69: g = 40'h38_54_54_54_18;
            7'd70: g = 40'h08_7E_09_01_02;
            7'd71: g = 40'h0C_52_52_52_3E;
            7'd72: g = 40'h7F_08_04_04_78;
            7'd73: g = 40'h00_44_7D_40_00;
            7'd74: g = 40'h20_40_44_3D_00;
            7'd75: g = 40'h7F_10_28_44_00;
            7'd76: g = 40'h00_41_7F_40_00;
            7'd77: g = 40'h7C_04_18_04_78;
            7'd78: g = 40'h7C_08_04_04_78;
            7'd79: g = 40'h38_44_44_44_38;
            7'd80: g = 40'h7C_14_14_14_08;
            7'd81: g = 40'h08_14_14_18_7C;
            7'd82: g = 40'h7C_08_04_04_08;
            7'd83: g = 40'h48_54_54_54_20;
            7'd84: g = 40'h04_3F_44_40_20;
            7'd85: g = 40'h3C_40_40_20_7C;
            7'd86: g = 40'h1C_20_40_20_1C;
            7'd87: g = 40'h3C_40_30_40_3C;
            7'd88: g = 40'h44_28_10_28_44;
            7'd89: g = 40'h0C_50_50_50_3C;
            7'd90: g = 40'h44_64_54_4C_44;
            7'd91: g = 40'h00_08_36_41_00;
            7'd92: g = 40'h00_00_7F_00_00;
            7'd93: g = 40'h00_41_36_08_00;
            7'd94: g = 40'h08_08_2A_1C_08;
            default: g = 40'h00_00_00_00_00;
        endcase
        return g;
    endfunction

endpackage

### hw/rtl/pftb_if.sv
// Request and response channel interfaces of the page framebuffer text blitter.
interface pftb_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] x;
    logic [7:0] y;
    logic       color;
    logic [7:0] char_code;
    logic [1:0] align;
    logic [5:0] text_len;
    logic [5:0] char_index;
    logic [9:0] byte_addr;

    modport source (output valid, req_type, x, y, color, char_code, align, text_len,
                    char_index, byte_addr, input ready);
    modport sink (input valid, req_type, x, y, color, char_code, align, text_len,
                  char_index, byte_addr, output ready);
endinterface

interface pftb_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] read_data;

    modport source (output valid, status, read_data, input ready);
    modport sink (input valid, status, read_data, output ready);
endinterface

### hw/rtl/pftb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pftb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### hw/rtl/page_framebuffer_text_blitter_top.sv
// Page framebuffer with pixel, byte read, clear and 5x7 character requests.
// A pixel request reads and rewrites one byte, a read request reads one byte,
// a clear writes every byte, and a character rewrites each page byte it touches.
// One request at a time; the next is taken only once the previous one is done.
// A new request is taken while the previous response waits on the output.
// Reset clears control state and marks the store not ready; a clear request
// zeroes the store and marks it ready. Store contents are not reset.
module page_framebuffer_text_blitter_top #(
    parameter int DISPLAY_WIDTH  = 128,
    parameter int DISPLAY_HEIGHT = 64
) (
    input logic      clk,
    input logic      rst_n,
    pftb_req_if.sink   req,
    pftb_rsp_if.source rsp
);
    import pftb_pkg::*;

    localparam int SIZE_RAW  = (DISPLAY_WIDTH * DISPLAY_HEIGHT) / 8;
    localparam int SIZE      = (SIZE_RAW > STORE_DEPTH) ? STORE_DEPTH : SIZE_RAW;

    state_t      state_reg, state_next;
    logic        ready_flag_reg, ready_flag_next;
    logic [1:0]  kind_reg, kind_next;
    logic [7:0]  x_reg, x_next;
    logic [7:0]  y_reg, y_next;
    logic        color_reg, color_next;
    logic [7:0]  code_reg, code_next;
    logic [1:0]  align_reg, align_next;
    logic [5:0]  len_reg, len_next;
    logic [5:0]  index_reg, index_next;
    logic [9:0]  baddr_reg, baddr_next;
    logic [STORE_AW-1:0] addr_reg, addr_next;
    logic [7:0]  mask_reg, mask_next;
    logic [7:0]  bits_reg, bits_next;
    logic [9:0]  cur_reg, cur_next;
    logic [2:0]  col_reg, col_next;
    logic        half_reg, half_next;
    logic [39:0] glyph_reg, glyph_next;
    logic [1:0]  res_status_reg, res_status_next;
    logic [7:0]  res_data_reg, res_data_next;
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  out_status_reg, out_status_next;
    logic [7:0]  out_data_reg, out_data_next;

    logic                ram_we;
    logic [STORE_AW-1:0] ram_waddr;
    logic [7:0]          ram_wdata;
    logic [STORE_AW-1:0] ram_raddr;
    logic [7:0]          ram_rdata;

    pftb_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Request checks and placement
    logic [8:0]  total;
    logic [8:0]  start;
    logic [8:0]  room;
    logic [9:0]  need;
    logic [12:0] pix_idx;
    logic [6:0]  gi;
    logic [7:0]  rowmask;
    logic [15:0] mask16;
    logic [15:0] bits16;
    logic [7:0]  gcol;
    logic [9:0]  colx;
    logic [4:0]  page;
    logic [12:0] col_idx;
    logic [7:0]  page_mask;
    logic [7:0]  page_bits;

    always_comb
    begin
        total = 9'({3'b0, len_reg} * 9'd6);
        case (align_reg)
            ALIGN_CENTER: start = (9'(DISPLAY_WIDTH) - total) >> 1;
            ALIGN_RIGHT:  start = 9'(DISPLAY_WIDTH) - total;
            default:      start = {1'b0, x_reg};
        endcase
        room    = 9'(DISPLAY_WIDTH) - start;
        need    = 10'(({4'b0, index_reg} + 10'd1) * 10'(CHAR_PITCH));
        pix_idx = 13'(x_reg) + 13'(y_reg[7:3]) * 13'(DISPLAY_WIDTH);
        if (code_reg < CODE_FIRST || code_reg > CODE_LAST)
        begin
            gi = 7'(CODE_SUBST - CODE_FIRST);
        end
        else
        begin
            gi = 7'(code_reg - CODE_FIRST);
        end
        for (int dy = 0; dy < 8; dy++)
        begin
            rowmask[dy] = (dy < GLYPH_ROWS) &&
                          (({1'b0, y_reg} + 9'(dy)) < 9'(DISPLAY_HEIGHT));
        end
        case (col_reg)
            3'd0:    gcol = glyph_reg[39:32];
            3'd1:    gcol = glyph_reg[31:24];
            3'd2:    gcol = glyph_reg[23:16];
            3'd3:    gcol = glyph_reg[15:8];
            default: gcol = glyph_reg[7:0];
        endcase
        mask16    = {8'b0, rowmask} << y_reg[2:0];
        bits16    = {8'b0, gcol & rowmask} << y_reg[2:0];
        colx      = cur_reg + 10'(col_reg);
        page      = 5'(y_reg[7:3]) + 5'(half_reg);
        col_idx   = 13'(colx) + 13'(page) * 13'(DISPLAY_WIDTH);
        page_mask = half_reg ? mask16[15:8] : mask16[7:0];
        page_bits = half_reg ? bits16[15:8] : bits16[7:0];
    end

    always_comb
    begin
        state_next      = state_reg;
        ready_flag_next = ready_flag_reg;
        kind_next       = kind_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        color_next      = color_reg;
        code_next       = code_reg;
        align_next      = align_reg;
        len_next        = len_reg;
        index_next      = index_reg;
        baddr_next      = baddr_reg;
        addr_next       = addr_reg;
        mask_next       = mask_reg;
        bits_next       = bits_reg;
        cur_next        = cur_reg;
        col_next        = col_reg;
        half_next       = half_reg;
        glyph_next      = glyph_reg;
        res_status_next = res_status_reg;
        res_data_next   = res_data_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        ram_we          = 1'b0;
        ram_waddr       = addr_reg;
        ram_wdata       = (ram_rdata & ~mask_reg) | bits_reg;
        ram_raddr       = addr_reg;
        req.ready       = (state_reg == ST_IDLE);

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    kind_next       = req.req_type;
                    x_next          = req.x;
                    y_next          = req.y;
                    color_next      = req.color;
                    code_next       = req.char_code;
                    align_next      = req.align;
                    len_next        = req.text_len;
                    index_next      = req.char_index;
                    baddr_next      = req.byte_addr;
                    res_status_next = STAT_OK;
                    res_data_next   = 8'd0;
                    state_next      = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = ST_DONE;
                if (kind_reg == REQ_CLEAR)
                begin
                    addr_next  = '0;
                    state_next = ST_CLEAR;
                end
                else if (!ready_flag_reg)
                begin
                    res_status_next = STAT_ERROR;
                end
                else if (kind_reg == REQ_PIXEL)
                begin
                    if (9'(x_reg) >= 9'(DISPLAY_WIDTH) || 9'(y_reg) >= 9'(DISPLAY_HEIGHT))
                    begin
                        res_status_next = STAT_ERROR;
                    end
                    else if (pix_idx < 13'(STORE_DEPTH))
                    begin
                        addr_next  = pix_idx[STORE_AW-1:0];
                        mask_next  = 8'd1 << y_reg[2:0];
                        bits_next  = color_reg ? (8'd1 << y_reg[2:0]) : 8'd0;
                        state_next = ST_RD;
                    end
                end
                else if (kind_reg == REQ_TEXT)
                begin
                    if (9'(x_reg) >= 9'(DISPLAY_WIDTH) || 9'(y_reg) >= 9'(DISPLAY_HEIGHT) ||
                        total > 9'(DISPLAY_WIDTH) || index_reg >= len_reg)
                    begin
                        res_status_next = STAT_ERROR;
                    end
                    else if (need > {1'b0, room})
                    begin
                        res_status_next = STAT_CLIPPED;
                    end
                    else
                    begin
                        cur_next   = 10'({1'b0, start} + {4'b0, index_reg} * 10'(CHAR_PITCH));
                        col_next   = '0;
                        half_next  = 1'b0;
                        glyph_next = glyph_bits(gi);
                        state_next = ST_TCOL;
                    end
                end
                else
                begin
                    if ({1'b0, baddr_reg} >= 11'(SIZE))
                    begin
                        res_status_next = STAT_ERROR;
                    end
                    else
                    begin
                        addr_next  = baddr_reg;
                        state_next = ST_RD;
                    end
                end
            end
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_wdata = 8'd0;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == STORE_AW'(STORE_DEPTH - 1))
                begin
                    ready_flag_next = 1'b1;
                    state_next      = ST_DONE;
                end
            end
            ST_TCOL:
            begin
                if (col_reg == 3'(GLYPH_COLS) || colx >= 10'(DISPLAY_WIDTH))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    // advance to the next page half or column
                    if (half_reg)
                    begin
                        half_next = 1'b0;
                        col_next  = col_reg + 1'b1;
                    end
                    else
                    begin
                        half_next = 1'b1;
                    end
                    if (page_mask != 8'd0 && col_idx < 13'(STORE_DEPTH))
                    begin
                        addr_next  = col_idx[STORE_AW-1:0];
                        mask_next  = page_mask;
                        bits_next  = page_bits;
                        state_next = ST_RD;
                    end
                end
            end
            ST_RD:
            begin
                state_next = (kind_reg == REQ_READ) ? ST_RDATA : ST_WR;
            end
            ST_WR:
            begin
                ram_we     = 1'b1;
                state_next = (kind_reg == REQ_PIXEL) ? ST_DONE : ST_TCOL;
            end
            ST_RDATA:
            begin
                res_data_next = ram_rdata;
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                // hold the result until the output register frees up
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_data_next   = res_data_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ready_flag_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ready_flag_reg <= ready_flag_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        x_reg          <= x_next;
        y_reg          <= y_next;
        color_reg      <= color_next;
        code_reg       <= code_next;
        align_reg      <= align_next;
        len_reg        <= len_next;
        index_reg      <= index_next;
        baddr_reg      <= baddr_next;
        addr_reg       <= addr_next;
        mask_reg       <= mask_next;
        bits_reg       <= bits_next;
        cur_reg        <= cur_next;
        col_reg        <= col_next;
        half_reg       <= half_next;
        glyph_reg      <= glyph_next;
        res_status_reg <= res_status_next;
        res_data_reg   <= res_data_next;
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.read_data = out_data_reg;

`ifndef SYNTHESIS
    a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WR |-> $past(state_reg) == ST_RD)
        else $error("write-back without a preceding read");
    a_we_states: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_CLEAR || state_reg == ST_WR))
        else $error("store written outside clear or write-back");
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> rsp.status != 2'd3)
        else $error("invalid status code");
`endif
endmodule

### bench/pftb_scoreboard.sv
// Request/response monitor, framebuffer predictor and comparator for the blitter.
module pftb_scoreboard #(
    parameter int DISPLAY_WIDTH  = 128,
    parameter int DISPLAY_HEIGHT = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    pftb_req_if.sink    req,
    pftb_rsp_if.sink    rsp,
    output int          fail_count,
    output int          pending_count,
    output int          response_count
);
    import pftb_pkg::*;

    typedef struct packed {
        status_t    status;
        logic [7:0] read_data;
    } blit_result_t;

    logic [7:0]   shadow_store [STORE_DEPTH];
    logic         shadow_ready;
    blit_result_t result_queue [$];

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d (response %0d)", what, got, want,
                 response_count);
        fail_count++;
    endtask

    function automatic void put_pixel(input int px, input int py, input bit on);
        int idx;
        idx = px + (py / 8) * DISPLAY_WIDTH;
        if (idx >= STORE_DEPTH)
            return;
        shadow_store[idx][py % 8] = on;
    endfunction

    function automatic logic [7:0] font_column(input int gi, input int col);
        logic [7:0] font [96][5] = '{
            '{8'h00,8'h00,8'h00,8'h00,8'h00},'{8'h00,8'h00,8'h5F,8'h00,8'h00},
            '{8'h00,8'h07,8'h00,8'h07,8'h00},'{8'h14,8'h7F,8'h14,8'h7F,8'h14},
            '{8'h24,8'h2A,8'h7F,8'h2A,8'h12},'{8'h23,8'h13,8'h08,8'h64,8'h62},
            '{8'h36,8'h49,8'h55,8'h22,8'h50},'{8'h00,8'h05,8'h03,8'h00,8'h00},
            '{8'h00,8'h1C,8'h22,8'h41,8'h00},'{8'h00,8'h41,8'h22,8'h1C,8'h00},
            '{8'h14,8'h08,8'h3E,8'h08,8'h14},'{8'h08,8'h08,8'h3E,8'h08,8'h08},
            '{8'h00,8'h50,8'h30,8'h00,8'h00},'{8'h08,8'h08,8'h08,8'h08,8'h08},
            '{8'h00,8'h60,8'h60,8'h00,8'h00},'{8'h20,8'h10,8'h08,8'h04,8'h02},
            '{8'h3E,8'h51,8'h49,8'h45,8'h3E},'{8'h00,8'h42,8'h7F,8'h40,8'h00},
            '{8'h42,8'h61,8'h51,8'h49,8'h46},'{8'h21,8'h41,8'h45,8'h4B,8'h31},
            '{8'h18,8'h14,8'h12,8'h7F,8'h10},'{8'h27,8'h45,8'h45,8'h45,8'h39},
            '{8'h3C,8'h4A,8'h49,8'h49,8'h30},'{8'h01,8'h71,8'h09,8'h05,8'h03},
            '{8'h36,8'h49,8'h49,8'h49,8'h36},'{8'h06,8'h49,8'h49,8'h29,8'h1E},
            '{8'h00,8'h36,8'h36,8'h00,8'h00},'{8'h00,8'h56,8'h36,8'h00,8'h00},
            '{8'h08,8'h14,8'h22,8'h41,8'h00},'{8'h14,8'h14,8'h14,8'h14,8'h14},
            '{8'h00,8'h41,8'h22,8'h14,8'h08},'{8'h02,8'h01,8'h51,8'h09,8'h06},
            '{8'h32,8'h49,8'h79,8'h41,8'h3E},'{8'h7E,8'h11,8'h11,8'h11,8'h7E},
            '{8'h7F,8'h49,8'h49,8'h49,8'h36},'{8'h3E,8'h41,8'h41,8'h41,8'h22},
            '{8'h7F,8'h41,8'h41,8'h22,8'h1C},'{8'h7F,8'h49,8'h49,8'h49,8'h41},
            '{8'h7F,8'h09,8'h09,8'h09,8'h01},'{8'h3E,8'h41,8'h49,8'h49,8'h7A},
            '{8'h7F,8'h08,8'h08,8'h08,8'h7F},'{8'h00,8'h41,8'h7F,8'h41,8'h00},
            '{8'h20,8'h40,8'h41,8'h3F,8'h01},'{8'h7F,8'h08,8'h14,8'h22,8'h41},
            '{8'h7F,8'h40,8'h40,8'h40,8'h40},'{8'h7F,8'h02,8'h0C,8'h02,8'h7F},
            '{8'h7F,8'h04,8'h08,8'h10,8'h7F},'{8'h3E,8'h41,8'h41,8'h41,8'h3E},
            '{8'h7F,8'h09,8'h09,8'h09,8'h06},'{8'h3E,8'h41,8'h51,8'h21,8'h5E},
            '{8'h7F,8'h09,8'h19,8'h29,8'h46},'{8'h46,8'h49,8'h49,8'h49,8'h31},
            '{8'h01,8'h01,8'h7F,8'h01,8'h01},'{8'h3F,8'h40,8'h40,8'h40,8'h3F},
            '{8'h1F,8'h20,8'h40,8'h20,8'h1F},'{8'h3F,8'h40,8'h38,8'h40,8'h3F},
            '{8'h63,8'h14,8'h08,8'h14,8'h63},'{8'h07,8'h08,8'h70,8'h08,8'h07},
            '{8'h61,8'h51,8'h49,8'h45,8'h43},'{8'h00,8'h7F,8'h41,8'h41,8'h00},
            '{8'h02,8'h04,8'h08,8'h10,8'h20},'{8'h00,8'h41,8'h41,8'h7F,8'h00},
            '{8'h04,8'h02,8'h01,8'h02,8'h04},'{8'h40,8'h40,8'h40,8'h40,8'h40},
            '{8'h00,8'h01,8'h02,8'h04,8'h00},'{8'h20,8'h54,8'h54,8'h54,8'h78},
            '{8'h7F,8'h48,8'h44,8'h44,8'h38},'{8'h38,8'h44,8'h44,8'h44,8'h20},
            '{8'h38,8'h44,8'h44,8'h48,8'h7F},'{8'h38,8'h54,8'h54,8'h54,8'h18},
            '{8'h08,8'h7E,8'h09,8'h01,8'h02},'{8'h0C,8'h52,8'h52,8'h52,8'h3E},
            '{8'h7F,8'h08,8'h04,8'h04,8'h78},'{8'h00,8'h44,8'h7D,8'h40,8'h00},
            '{8'h20,8'h40,8'h44,8'h3D,8'h00},'{8'h7F,8'h10,8'h28,8'h44,8'h00},
            '{8'h00,8'h41,8'h7F,8'h40,8'h00},'{8'h7C,8'h04,8'h18,8'h04,8'h78},
            '{8'h7C,8'h08,8'h04,8'h04,8'h78},'{8'h38,8'h44,8'h44,8'h44,8'h38},
            '{8'h7C,8'h14,8'h14,8'h14,8'h08},'{8'h08,8'h14,8'h14,8'h18,8'h7C},
            '{8'h7C,8'h08,8'h04,8'h04,8'h08},'{8'h48,8'h54,8'h54,8'h54,8'h20},
            '{8'h04,8'h3F,8'h44,8'h40,8'h20},'{8'h3C,8'h40,8'h40,8'h20,8'h7C},
            '{8'h1C,8'h20,8'h40,8'h20,8'h1C},'{8'h3C,8'h40,8'h30,8'h40,8'h3C},
            '{8'h44,8'h28,8'h10,8'h28,8'h44},'{8'h0C,8'h50,8'h50,8'h50,8'h3C},
            '{8'h44,8'h64,8'h54,8'h4C,8'h44},'{8'h00,8'h08,8'h36,8'h41,8'h00},
            '{8'h00,8'h00,8'h7F,8'h00,8'h00},'{8'h00,8'h41,8'h36,8'h08,8'h00},
            '{8'h08,8'h08,8'h2A,8'h1C,8'h08},'{8'h00,8'h00,8'h00,8'h00,8'h00}};
        return font[gi][col];
    endfunction

    function automatic status_t render_char(input int x, input int y, input int code,
                                            input int align, input int len, input int index);
        int total;
        int start;
        int limit;
        int cur;
        logic [39:0] g;
        logic [7:0] col;
        total = len * CHAR_PITCH;
        start = x;
        if (x >= DISPLAY_WIDTH || y >= DISPLAY_HEIGHT)
            return STAT_ERROR;
        if (total > DISPLAY_WIDTH || index >= len)
            return STAT_ERROR;
        if (align == ALIGN_CENTER)
            start = (DISPLAY_WIDTH - total) / 2;
        else if (align == ALIGN_RIGHT)
            start = DISPLAY_WIDTH - total;
        limit = (DISPLAY_WIDTH - start) / CHAR_PITCH;
        if (index >= limit)
            return STAT_CLIPPED;
        if (code < CODE_FIRST || code > CODE_LAST)
            code = CODE_SUBST;
        cur = start + index * CHAR_PITCH;
        for (int dx = 0; dx < GLYPH_COLS && cur + dx < DISPLAY_WIDTH; dx++)
        begin
            // Glyph columns are held in a local copy of the font table.
            col = font_column(code - CODE_FIRST, dx);
            for (int dy = 0; dy < GLYPH_ROWS && y + dy < DISPLAY_HEIGHT; dy++)
                put_pixel(cur + dx, y + dy, col[dy]);
        end
        return STAT_OK;
    endfunction

    function automatic blit_result_t serve_request(input req_kind_t kind, input int x,
            input int y, input bit color, input int code, input int align,
            input int len, input int index, input int addr);
        blit_result_t r;
        int size;
        r.status    = STAT_OK;
        r.read_data = '0;
        size = (DISPLAY_WIDTH * DISPLAY_HEIGHT) / 8;
        if (size > STORE_DEPTH)
            size = STORE_DEPTH;
        if (kind == REQ_CLEAR)
        begin
            foreach (shadow_store[i])
                shadow_store[i] = '0;
            shadow_ready = 1'b1;
        end
        else if (!shadow_ready)
            r.status = STAT_ERROR;
        else if (kind == REQ_PIXEL)
        begin
            if (x >= DISPLAY_WIDTH || y >= DISPLAY_HEIGHT)
                r.status = STAT_ERROR;
            else
                put_pixel(x, y, color);
        end
        else if (kind == REQ_TEXT)
            r.status = render_char(x, y, code, align, len, index);
        else if (addr >= size)
            r.status = STAT_ERROR;
        else
            r.read_data = shadow_store[addr];
        return r;
    endfunction

    assign pending_count = result_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        blit_result_t want;
        if (!rst_n)
        begin
            foreach (shadow_store[i])
                shadow_store[i] = '0;
            shadow_ready = 1'b0;
            fail_count     = 0;
            response_count <= 0;
        end
        else
        begin
            // Check the response before the same-edge request updates the image.
            if (rsp.valid && rsp.ready)
            begin
                response_count <= response_count + 1;
                if (result_queue.size() == 0)
                    report_mismatch("unexpected response status", rsp.status, -1);
                else
                begin
                    want = result_queue.pop_front();
                    if (rsp.status !== want.status)
                        report_mismatch("status", rsp.status, want.status);
                    if (rsp.read_data !== want.read_data)
                        report_mismatch("read_data", rsp.read_data, want.read_data);
                end
            end
            if (req.valid && req.ready)
                result_queue.push_back(serve_request(req_kind_t'(req.req_type), req.x,
                    req.y, req.color, req.char_code, req.align, req.text_len,
                    req.char_index, req.byte_addr));
        end
    end
endmodule

### bench/page_framebuffer_text_blitter_top_tb.sv
// Stimulus, clock, reset and verdict for the page framebuffer text blitter.
module page_framebuffer_text_blitter_top_tb;
    import pftb_pkg::*;

    localparam int W = 128;
    localparam int H = 64;
    localparam int RANDOM_REQUESTS = 1430;
    localparam int CYCLE_LIMIT = 1000000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_count;
    int   response_count;
    int   cycle_count;
    int   sent_count;
    bit   quiet_phase;
    bit   hold_off;

    pftb_req_if req ();
    pftb_rsp_if rsp ();

    page_framebuffer_text_blitter_top #(.DISPLAY_WIDTH(W), .DISPLAY_HEIGHT(H)) DUT (
        .clk(clk), .rst_n(rst_n), .req(req.sink), .rsp(rsp.source)
    );

    pftb_scoreboard #(.DISPLAY_WIDTH(W), .DISPLAY_HEIGHT(H)) scoreboard (
        .clk(clk), .rst_n(rst_n), .req(req.sink), .rsp(rsp.sink),
        .fail_count(fail_count), .pending_count(pending_count),
        .response_count(response_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles, %0d responses", cycle_count,
                         response_count);
                $display("status: fail");
                $finish;
            end
        end
    end

    // Present one request and hold it until it is taken.
    task automatic send_request(input req_kind_t kind, input int x, input int y,
            input bit color, input int code, input int align, input int len,
            input int index, input int addr);
        int gap;
        if (!quiet_phase && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 13);
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid      <= 1'b1;
        req.req_type   <= kind;
        req.x          <= 8'(x);
        req.y          <= 8'(y);
        req.color      <= color;
        req.char_code  <= 8'(code);
        req.align      <= 2'(align);
        req.text_len   <= 6'(len);
        req.char_index <= 6'(index);
        req.byte_addr  <= 10'(addr);
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        sent_count++;
    endtask

    task automatic send_char(input int x, input int y, input int code, input int align,
                             input int len, input int index);
        send_request(REQ_TEXT, x, y, $urandom_range(0, 1), code, align, len, index,
                     $urandom_range(0, 1023));
    endtask

    // Clear, pixel, read and mostly well-formed character requests, some noise.
    task automatic random_request();
        int pick;
        int len;
        pick = $urandom_range(0, 99);
        if (pick < 2)
            send_request(REQ_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom);
        else if (pick < 30)
            send_request(REQ_PIXEL, $urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                         : $urandom_range(0, W - 1), $urandom_range(0, 3) == 0 ?
                         $urandom_range(0, 255) : $urandom_range(0, H - 1), $urandom,
                         $urandom, $urandom, $urandom, $urandom, $urandom);
        else if (pick < 55)
            send_request(REQ_READ, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom_range(0, 3) == 0 ?
                         $urandom_range(0, 1023) : $urandom_range(0, W * H / 8 - 1));
        else if (pick < 90)
        begin
            len = $urandom_range(1, W / CHAR_PITCH);
            send_char($urandom_range(0, W - 1), $urandom_range(0, H - 1),
                      $urandom_range(0, 255), $urandom_range(0, 3), len,
                      $urandom_range(0, len - 1));
        end
        else
            send_char($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    // Receiver stalls in bursts; one long hold-off fills the block.
    initial
    begin
        int gap;
        rsp.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
                rsp.ready <= 1'b0;
            else if (!quiet_phase && $urandom_range(0, 4) == 0)
            begin
                gap = $urandom_range(1, 13);
                rsp.ready <= 1'b0;
                repeat (gap) @(posedge clk);
                rsp.ready <= 1'b1;
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    initial
    begin
        int drain;
        quiet_phase = 1'b0;
        hold_off    = 1'b0;
        sent_count  = 0;
        rst_n       = 1'b0;
        req.valid <= 1'b0;
        req.req_type <= REQ_PIXEL;
        req.x <= '0;
        req.y <= '0;
        req.color <= 1'b0;
        req.char_code <= '0;
        req.align <= '0;
        req.text_len <= '0;
        req.char_index <= '0;
        req.byte_addr <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Requests before any clear must be refused.
        send_request(REQ_PIXEL, 3, 3, 1, 0, 0, 0, 0, 0);
        send_char(0, 0, 65, ALIGN_LEFT, 1, 0);
        send_request(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0);
        send_request(REQ_CLEAR, 255, 255, 1, 255, 3, 63, 63, 1023);
        send_request(REQ_PIXEL, 0, 0, 1, 0, 0, 0, 0, 0);
        send_request(REQ_PIXEL, W - 1, H - 1, 1, 0, 0, 0, 0, 0);
        send_request(REQ_PIXEL, W, 0, 1, 0, 0, 0, 0, 0);
        send_request(REQ_PIXEL, 0, 255, 1, 0, 0, 0, 0, 0);
        send_request(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0);
        send_request(REQ_READ, 0, 0, 0, 0, 0, 0, 0, W * H / 8 - 1);
        send_request(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 1023);
        send_request(REQ_PIXEL, 0, 0, 0, 0, 0, 0, 0, 0);
        send_char(0, 0, 32, ALIGN_LEFT, 1, 0);
        send_char(10, H - 3, 255, ALIGN_CENTER, 5, 2);
        send_char(W - 2, 20, 127, ALIGN_LEFT, 3, 0);
        send_char(W - 8, 8, 66, ALIGN_LEFT, 3, 2);
        send_char(0, 30, 0, ALIGN_RIGHT, W / CHAR_PITCH, W / CHAR_PITCH - 1);
        send_char(0, 30, 90, 3, 4, 1);
        send_char(0, 0, 65, ALIGN_LEFT, 22, 0);
        send_char(0, 0, 65, ALIGN_LEFT, 63, 0);
        send_char(5, 5, 65, ALIGN_LEFT, 4, 4);
        send_char(5, 5, 65, ALIGN_LEFT, 0, 0);
        send_char(W, 5, 65, ALIGN_LEFT, 1, 0);
        send_char(5, H, 65, ALIGN_LEFT, 1, 0);
        send_request(REQ_READ, 0, 0, 0, 0, 0, 0, 0, W + 5);

        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
        join_none
        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            if (i == RANDOM_REQUESTS - 200)
                quiet_phase = 1'b1;
            random_request();
        end
        req.valid <= 1'b0;

        while (pending_count != 0)
            @(posedge clk);
        drain = 0;
        while (drain < 40)
        begin
            @(posedge clk);
            drain++;
        end
        $display("covered %0d requests: pixel, read, clear and aligned text with clipping,",
                 sent_count);
        $display("errors and back-pressure; %0d responses checked", response_count);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
